### hdl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared widths, constants, queue status and ramp segment codes.
// ----------------------------------------------------------------------------
package hsl_pkg;

	// Default internal precision in fractional bits.
	localparam int FRAC_BITS_DEF = 12;

	// Input fixed point: 12 fractional bits, 4096 means 1.0.
	localparam int IN_FRAC = 12;
	localparam int HUE_W   = 12;
	localparam int SL_W    = 13;
	localparam int CH_W    = 8;
	localparam logic [SL_W-1:0] IN_ONE = 13'd4096;

	// Stream widths.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	// Queue between front and back, and stage counts.
	localparam int QUEUE_DEPTH  = 2;
	localparam int FRONT_STAGES = 1;
	localparam int BACK_STAGES  = 6;

	// Segment of the hue ramp a channel falls in.
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Width of one classified item: grey, low-half flag, s, l and three hues.
	function automatic int item_width(int frac_bits);
		return 5 * frac_bits + 10;
	endfunction

endpackage

### hdl/hsl_to_rgb_core.sv
// Path: front input register, item queue, then back stages 2 to 7 to the output.
// Throughput: one item per cycle while m_tready holds, set by the back-end
// pipeline and its single output register; the front keeps taking items while
// the back stalls until its input register and the two-entry queue are full.
// Reset: arst_n clears all valid flags and queue pointers at once; the block
// is ready to take items as soon as reset is released.
// ----------------------------------------------------------------------------
// HSL to RGB converter, top level
// Front end, item queue and back-end pipeline for HSL to 8-bit RGB conversion.
// ----------------------------------------------------------------------------
module hsl_to_rgb_core #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: hue[11:0], saturation[24:12], lightness[37:25], zeros[39:38]
	input  logic [hsl_pkg::S_TDATA_W-1:0] s_tdata,
	// Result item.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: red[7:0], green[15:8], blue[23:16]
	output logic [hsl_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int ITEM_W = hsl_pkg::item_width(FRAC_BITS);

	logic                 push, pop;
	logic [ITEM_W-1:0]    item_in, item_out;
	hsl_pkg::queue_stat_t q_stat;

	hsl_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.item     (item_in),
		.q_stat   (q_stat)
	);

	hsl_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (hsl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item_in),
		.pop    (pop),
		.rdata  (item_out),
		.stat   (q_stat)
	);

	hsl_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_out),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### hdl/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front end
// Takes input items, clamps and rescales them and forms the three channel hues.
// ----------------------------------------------------------------------------
module hsl_front #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [hsl_pkg::S_TDATA_W-1:0]               s_tdata,
	output logic                                        push,
	output logic [hsl_pkg::item_width(FRAC_BITS)-1:0]   item,
	input  hsl_pkg::queue_stat_t                        q_stat
);

	localparam int XW = FRAC_BITS + 2;
	localparam int LW = FRAC_BITS + 1;
	localparam logic [XW:0] ONE_X  = (XW+1)'(1) << FRAC_BITS;
	localparam logic [XW:0] TWO_X  = ONE_X << 1;
	localparam logic [XW:0] TURN_X = ONE_X + TWO_X;

	logic                         v_s1;
	logic [hsl_pkg::HUE_W-1:0]    hue_s1;
	logic [hsl_pkg::SL_W-1:0]     sat_s1;
	logic [hsl_pkg::SL_W-1:0]     lig_s1;

	logic [hsl_pkg::SL_W-1:0]            sat_cl, lig_cl;
	logic [FRAC_BITS+hsl_pkg::SL_W-1:0]  s_wide, l_wide;
	logic [FRAC_BITS+hsl_pkg::HUE_W-1:0] h_wide;
	logic [LW-1:0]                       s, l;
	logic [FRAC_BITS-1:0]                h;
	logic [XW-1:0]                       xg, xr, xb;
	logic [XW:0]                         xr_sum, xb_sum;
	logic                                grey, lt_half;

	// The input register empties whenever the queue has room.
	assign push     = v_s1 && !q_stat.full;
	assign s_tready = !v_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hue_s1 <= s_tdata[hsl_pkg::HUE_W-1:0];
			sat_s1 <= s_tdata[hsl_pkg::HUE_W +: hsl_pkg::SL_W];
			lig_s1 <= s_tdata[hsl_pkg::HUE_W+hsl_pkg::SL_W +: hsl_pkg::SL_W];
		end
	end

	// Clamp to 1.0 and rescale to the internal precision, truncating.
	always_comb begin
		sat_cl = (sat_s1 > hsl_pkg::IN_ONE) ? hsl_pkg::IN_ONE : sat_s1;
		lig_cl = (lig_s1 > hsl_pkg::IN_ONE) ? hsl_pkg::IN_ONE : lig_s1;
		s_wide = ({{FRAC_BITS{1'b0}}, sat_cl} << FRAC_BITS) >> hsl_pkg::IN_FRAC;
		l_wide = ({{FRAC_BITS{1'b0}}, lig_cl} << FRAC_BITS) >> hsl_pkg::IN_FRAC;
		h_wide = ({{FRAC_BITS{1'b0}}, hue_s1} << FRAC_BITS) >> hsl_pkg::IN_FRAC;
		s = s_wide[LW-1:0];
		l = l_wide[LW-1:0];
		h = h_wide[FRAC_BITS-1:0];
	end

	// Hue kept as 3h so one third of a turn is exact; red and blue wrap.
	always_comb begin
		xg     = {2'b00, h} + {1'b0, h, 1'b0};
		xr_sum = {1'b0, xg} + ONE_X;
		xb_sum = {1'b0, xg} + TWO_X;
		xr     = (xr_sum >= TURN_X) ? XW'(xr_sum - TURN_X) : xr_sum[XW-1:0];
		xb     = (xb_sum >= TURN_X) ? XW'(xb_sum - TURN_X) : xb_sum[XW-1:0];
		grey    = (s == '0);
		lt_half = ({1'b0, l, 1'b0} < ONE_X);
	end

	assign item = {grey, lt_half, s, l, xr, xg, xb};

endmodule

### hdl/hsl_queue.sv
// ----------------------------------------------------------------------------
// HSL item queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module hsl_queue #(
	parameter int WIDTH = 70,
	parameter int DEPTH = hsl_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     rdata,
	output hsl_pkg::queue_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hdl/hsl_back.sv
// ----------------------------------------------------------------------------
// HSL back end
// Six-stage pipeline that forms the two levels, the ramps and the 8-bit levels.
// ----------------------------------------------------------------------------
module hsl_back #(
	parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [hsl_pkg::item_width(FRAC_BITS)-1:0]   item,
	input  hsl_pkg::queue_stat_t                        q_stat,
	output logic                                        pop,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [hsl_pkg::M_TDATA_W-1:0]               m_tdata
);

	localparam int F  = FRAC_BITS;
	localparam int XW = F + 2;
	localparam int LW = F + 1;
	localparam int HW = 2 * F + 1;
	localparam int MW = F + 1;
	localparam int PW = HW + MW;
	localparam int CW = 3 * F + 1;
	localparam int TW = CW + hsl_pkg::CH_W + 1;
	localparam logic [XW:0] ONE_X   = (XW+1)'(1) << F;
	localparam logic [XW:0] TWO_X   = ONE_X << 1;
	localparam logic [XW:0] THREE_X = ONE_X + TWO_X;
	localparam logic [TW-1:0] HALF  = TW'(1) << (3 * F - 1);

	// Ramp segment for a hue given in thirds of a turn.
	function automatic hsl_pkg::seg_t seg_of(logic [XW-1:0] x);
		logic [XW:0] x2;
		x2 = {x, 1'b0};
		if (x2 < ONE_X) begin
			return hsl_pkg::SEG_RISE;
		end else if (x2 < THREE_X) begin
			return hsl_pkg::SEG_HIGH;
		end else if ({1'b0, x} < TWO_X) begin
			return hsl_pkg::SEG_FALL;
		end
		return hsl_pkg::SEG_LOW;
	endfunction

	// Multiplier argument of the sloped segments.
	function automatic logic [MW-1:0] arg_of(logic [XW-1:0] x, hsl_pkg::seg_t seg);
		logic [XW:0] x2, diff;
		x2   = {x, 1'b0};
		diff = TWO_X - {1'b0, x};
		case (seg)
			hsl_pkg::SEG_RISE: return x2[MW-1:0];
			hsl_pkg::SEG_FALL: return {diff[F-1:0], 1'b0};
			default:           return '0;
		endcase
	endfunction

	logic en;
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [XW-1:0]         xi [3];
	logic [LW-1:0]         s_in, l_in;
	logic                  lt_in, grey_in;

	logic [2*LW-1:0]       p_s2;
	logic [LW-1:0]         l_s2, s_s2;
	logic                  lt_s2, grey_s2;
	hsl_pkg::seg_t         seg_s2 [3];
	logic [MW-1:0]         arg_s2 [3];

	logic [HW-1:0]         hi_s3;
	logic [LW-1:0]         l_s3;
	hsl_pkg::seg_t         seg_s3 [3];
	logic [MW-1:0]         arg_s3 [3];

	logic [HW-1:0]         hi_s4, lo_s4, d_s4;
	hsl_pkg::seg_t         seg_s4 [3];
	logic [MW-1:0]         arg_s4 [3];

	logic [HW-1:0]         hi_s5, lo_s5;
	hsl_pkg::seg_t         seg_s5 [3];
	logic [PW-1:0]         prod_s5 [3];

	logic [CW-1:0]         c3_s6 [3];
	logic [hsl_pkg::CH_W-1:0] lvl_s7 [3];

	logic [HW:0]           hi_lt, hi_ge, two_l;
	logic [TW-1:0]         t_lvl [3];
	logic [CW:0]           c3_sum [3];

	// The whole back end moves whenever the output register can take an item.
	assign en       = !v_s7 || m_tready;
	assign pop      = en && !q_stat.empty;
	assign m_tvalid = v_s7;
	assign m_tdata  = {lvl_s7[2], lvl_s7[1], lvl_s7[0]};

	// Unpack the classified item; lanes are red, green, blue.
	assign xi[2]   = item[XW-1:0];
	assign xi[1]   = item[2*XW-1:XW];
	assign xi[0]   = item[3*XW-1:2*XW];
	assign l_in    = item[3*XW+LW-1:3*XW];
	assign s_in    = item[3*XW+2*LW-1:3*XW+LW];
	assign lt_in   = item[3*XW+2*LW];
	assign grey_in = item[3*XW+2*LW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= !q_stat.empty;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 2: product S*L, ramp segment and multiplier argument per lane.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= s_in * l_in;
			l_s2    <= l_in;
			s_s2    <= s_in;
			lt_s2   <= lt_in;
			grey_s2 <= grey_in;
			for (int i = 0; i < 3; i++) begin
				seg_s2[i] <= grey_in ? hsl_pkg::SEG_HIGH : seg_of(xi[i]);
				arg_s2[i] <= arg_of(xi[i], seg_of(xi[i]));
			end
		end
	end

	// Stage 3: upper level with 2F fractional bits; grey takes L itself.
	always_comb begin
		hi_lt = {1'b0, l_s2, {F{1'b0}}} + (HW+1)'(p_s2);
		hi_ge = {({1'b0, l_s2} + {1'b0, s_s2}), {F{1'b0}}} - (HW+1)'(p_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (grey_s2) begin
				hi_s3 <= {l_s2, {F{1'b0}}};
			end else if (lt_s2) begin
				hi_s3 <= hi_lt[HW-1:0];
			end else begin
				hi_s3 <= hi_ge[HW-1:0];
			end
			l_s3   <= l_s2;
			seg_s3 <= seg_s2;
			arg_s3 <= arg_s2;
		end
	end

	// Stage 4: lower level and the span between the two.
	assign two_l = {l_s3, 1'b0, {F{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s4  <= hi_s3;
			lo_s4  <= HW'(two_l - {1'b0, hi_s3});
			d_s4   <= HW'({hi_s3, 1'b0} - two_l);
			seg_s4 <= seg_s3;
			arg_s4 <= arg_s3;
		end
	end

	// Stage 5: slope times position on the ramp, one multiplier per lane.
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s5  <= hi_s4;
			lo_s5  <= lo_s4;
			seg_s5 <= seg_s4;
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= d_s4 * arg_s4[i];
			end
		end
	end

	// Stage 6: ramp value with 3F fractional bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c3_sum[i] = {1'b0, lo_s5, {F{1'b0}}} + (CW+1)'(prod_s5[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				case (seg_s5[i])
					hsl_pkg::SEG_RISE,
					hsl_pkg::SEG_FALL: c3_s6[i] <= c3_sum[i][CW-1:0];
					hsl_pkg::SEG_HIGH: c3_s6[i] <= {hi_s5, {F{1'b0}}};
					default:           c3_s6[i] <= {lo_s5, {F{1'b0}}};
				endcase
			end
		end
	end

	// Stage 7: scale by 255, round half up and saturate; this is the output register.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_lvl[i] = ({c3_s6[i], {hsl_pkg::CH_W{1'b0}}} - TW'(c3_s6[i])) + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lvl_s7[i] <= (|t_lvl[i][TW-1:3*F+hsl_pkg::CH_W]) ? {hsl_pkg::CH_W{1'b1}}
				                                                 : t_lvl[i][3*F +: hsl_pkg::CH_W];
			end
		end
	end

endmodule

### hdl/hsl_core_chk.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter checker
// Watches the top-level ports and tracks the number of items in flight.
// ----------------------------------------------------------------------------
module hsl_core_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hsl_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CAP = hsl_pkg::FRONT_STAGES + hsl_pkg::QUEUE_DEPTH
	                   + hsl_pkg::BACK_STAGES;

	logic [4:0] inflight_q;

	// Items accepted at the input and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 5'(s_tvalid && s_tready) - 5'(m_tvalid && m_tready);
		end
	end

	// A result is only shown for an item that was taken in.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (inflight_q != '0))
		else $error("result shown with no item in flight");

	// The block never holds more items than its stages and queue can store.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 5'(CAP))
		else $error("more items in flight than storage");

	// The input only stalls once the front register and the queue are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (inflight_q >= 5'(hsl_pkg::FRONT_STAGES + hsl_pkg::QUEUE_DEPTH)))
		else $error("input stalled with room left");

	// A stalled result keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind hsl_to_rgb_core hsl_core_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/hsl_rgb_checker.sv
// ----------------------------------------------------------------------------
// HSL to RGB result checker
// Watches both streams of the converter, predicts the RGB triple for every
// accepted input item and compares each accepted result in order.
// ----------------------------------------------------------------------------
module hsl_rgb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// s_tdata: hue[11:0], saturation[24:12], lightness[37:25], zeros[39:38]
	input  logic [hsl_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: red[7:0], green[15:8], blue[23:16]
	input  logic [hsl_pkg::M_TDATA_W-1:0] m_tdata,
	output int                            fail_count,
	output int                            pending
);

	localparam int FB = hsl_pkg::FRAC_BITS_DEF;
	localparam logic [63:0] ONE = 64'd1 << FB;

	// One expected color together with the input that produced it.
	typedef struct {
		logic [hsl_pkg::HUE_W-1:0] hue;
		logic [hsl_pkg::SL_W-1:0]  sat;
		logic [hsl_pkg::SL_W-1:0]  light;
		logic [7:0]                red;
		logic [7:0]                green;
		logic [7:0]                blue;
	} color_t;

	color_t colors_due[$];
	color_t want;

	// Ramp value with 3*FB fractional bits; x counts thirds of a turn in ONE units.
	function automatic logic [63:0] ramp_level(input logic [63:0] lo2, input logic [63:0] hi2,
			input logic [63:0] x);
		logic [63:0] d;
		logic [63:0] base;
		d    = hi2 - lo2;
		base = lo2 << FB;
		if (2 * x < ONE)
			return base + d * (2 * x);
		if (2 * x < 3 * ONE)
			return hi2 << FB;
		if (x < 2 * ONE)
			return base + d * (2 * (2 * ONE - x));
		return base;
	endfunction

	// Scale to 0..255, round half up and saturate.
	function automatic logic [7:0] channel_byte(input logic [63:0] c3);
		logic [63:0] v;
		v = (64'd255 * c3 + (64'd1 << (3 * FB - 1))) >> (3 * FB);
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic color_t predict_color(input logic [hsl_pkg::S_TDATA_W-1:0] data);
		color_t      c;
		logic [63:0] h, s, l, s_in, l_in, hi2, lo2, x, r3, g3, b3;
		c.hue   = data[11:0];
		c.sat   = data[24:12];
		c.light = data[37:25];
		h    = (64'(c.hue) << FB) >> hsl_pkg::IN_FRAC;
		s_in = 64'(c.sat);
		l_in = 64'(c.light);
		// Saturation and lightness clip at 1.0.
		if (s_in > 64'(hsl_pkg::IN_ONE))
			s_in = 64'(hsl_pkg::IN_ONE);
		if (l_in > 64'(hsl_pkg::IN_ONE))
			l_in = 64'(hsl_pkg::IN_ONE);
		s = (s_in << FB) >> hsl_pkg::IN_FRAC;
		l = (l_in << FB) >> hsl_pkg::IN_FRAC;
		if (h >= ONE)
			h = ONE - 1;
		if (s == 0) begin
			// Grey at the lightness.
			r3 = l << (2 * FB);
			g3 = r3;
			b3 = r3;
		end else begin
			if (2 * l < ONE)
				hi2 = l * (ONE + s);
			else
				hi2 = (l + s) * ONE - s * l;
			lo2 = 2 * l * ONE - hi2;
			x   = 3 * h;
			r3  = ramp_level(lo2, hi2, (x + ONE) % (3 * ONE));
			g3  = ramp_level(lo2, hi2, x);
			b3  = ramp_level(lo2, hi2, (x + 2 * ONE) % (3 * ONE));
		end
		c.red   = channel_byte(r3);
		c.green = channel_byte(g3);
		c.blue  = channel_byte(b3);
		return c;
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic compare_channel(input string name, input logic [7:0] got,
			input logic [7:0] exp_val);
		if (got !== exp_val)
			flag_mismatch($sformatf("%s got %0d expected %0d (h=%0d s=%0d l=%0d)",
				name, got, exp_val, want.hue, want.sat, want.light));
	endtask

	// Results are checked before new items are queued in the same cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			colors_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (colors_due.size() == 0) begin
					flag_mismatch($sformatf("result %h with no item outstanding", m_tdata));
				end else begin
					want = colors_due.pop_front();
					compare_channel("red", m_tdata[7:0], want.red);
					compare_channel("green", m_tdata[15:8], want.green);
					compare_channel("blue", m_tdata[23:16], want.blue);
				end
			end
			if (s_tvalid && s_tready)
				colors_due.push_back(predict_color(s_tdata));
			pending = colors_due.size();
		end
	end

endmodule

### tb/hsl_to_rgb_core_tb.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives directed and random colors with random gaps on both streams; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hsl_to_rgb_core_tb;

	localparam int RANDOM_ITEMS = 1450;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [hsl_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [hsl_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          steady   = 1'b0;
	int                            fail_count;
	int                            pending;

	always #10 clk = ~clk;

	hsl_to_rgb_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsl_rgb_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// The receiver stalls at random except during the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 18);
	end

	// Offers one color, after a random gap, and waits until it is taken.
	task automatic send_color(input logic [11:0] h, input logic [12:0] s,
			input logic [12:0] l);
		while (!steady && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {8'($urandom()), $urandom()};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, l, s, h};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Mostly in-range levels, with greys, clipped values and extremes mixed in.
	function automatic logic [12:0] pick_level();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 13'($urandom_range(8191, 4097));
		if (roll < 12)
			return ($urandom_range(1)) ? 13'd4096 : 13'd0;
		return 13'($urandom_range(4096));
	endfunction

	task automatic send_random();
		logic [11:0] h;
		logic [12:0] s, l;
		h = 12'($urandom_range(4095));
		s = ($urandom_range(99) < 10) ? 13'd0 : pick_level();
		l = pick_level();
		send_color(h, s, l);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Greys at the extremes and the midpoint.
		send_color(12'd0, 13'd0, 13'd0);
		send_color(12'd4095, 13'd0, 13'd4096);
		send_color(12'd1234, 13'd0, 13'd2048);
		// Full saturation at the three primaries and at yellow and cyan.
		send_color(12'd0, 13'd4096, 13'd2048);
		send_color(12'd1365, 13'd4096, 13'd2048);
		send_color(12'd2731, 13'd4096, 13'd2048);
		send_color(12'd683, 13'd4096, 13'd2048);
		send_color(12'd2048, 13'd4096, 13'd2048);
		// Hues at the edges of the rising, flat and falling segments.
		send_color(12'd682, 13'd3000, 13'd1500);
		send_color(12'd2047, 13'd3000, 13'd2500);
		send_color(12'd2730, 13'd3000, 13'd1500);
		send_color(12'd1366, 13'd3000, 13'd2500);
		send_color(12'd4095, 13'd4096, 13'd2047);
		// Lightness just below and at one half.
		send_color(12'd300, 13'd2000, 13'd2047);
		send_color(12'd300, 13'd2000, 13'd2048);
		// Black and white with nonzero saturation.
		send_color(12'd1000, 13'd4096, 13'd0);
		send_color(12'd1000, 13'd4096, 13'd4096);
		// Saturation and lightness above one are clipped, with one near-zero pair.
		send_color(12'd3500, 13'd8191, 13'd1000);
		send_color(12'd3500, 13'd2500, 13'd8191);
		send_color(12'd2222, 13'd8191, 13'd8191);
		send_color(12'd4095, 13'd4097, 13'd4097);
		send_color(12'd2730, 13'd1, 13'd1);
		send_color(12'd2048, 13'd5461, 13'd2730);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady <= (i >= 500 && i < 800);
			send_random();
		end
		s_tvalid <= 1'b0;
		steady   <= 1'b0;

		// Drain, then give the pipeline time to show any stray result.
		do
			@(negedge clk);
		while (pending != 0);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hdl/hsl_pkg.sv
hdl/hsl_front.sv
hdl/hsl_queue.sv
hdl/hsl_back.sv
hdl/hsl_to_rgb_core.sv
hdl/hsl_core_chk.sv
tb/hsl_rgb_checker.sv
tb/hsl_to_rgb_core_tb.sv
